### hdl/swq_pkg.sv
// shared types for the sliding window quantile unit
package swq_pkg;

  localparam int WINDOW_MAX_DEF  = 512;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int LEN_BITS        = 10;
  localparam int Q_BITS          = 17;
  localparam int FRAC_BITS       = 16;
  localparam logic [LEN_BITS-1:0] LEN_RESET = 10'd300;
  localparam logic [Q_BITS-1:0]   Q_RESET   = 17'd64225;
  localparam logic [Q_BITS-1:0]   Q_ONE     = 17'd65536;

  typedef enum logic [0:0] {
    REG_WINDOW_LENGTH     = 1'b0,
    REG_QUANTILE_FRACTION = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_SELECT,
    ST_INTERP
  } state_t;

  // broadcast control for the sorted cell row
  typedef struct packed {
    logic upd;    // apply insert and evict this cycle
    logic evict;  // oldest sample leaves the window
    logic vle;    // evicted value is <= new sample
  } cell_ctrl_t;

endpackage

### hdl/swq_cell.sv
// one slot of the sorted window: holds, shifts left, shifts right or takes the new sample
module swq_cell #(
  parameter int SB  = 24,
  parameter int CW  = 10,
  parameter int IDX = 0
) (
  input  logic                  clk,
  input  swq_pkg::cell_ctrl_t   ctrl,
  input  logic signed [SB-1:0]  x,
  input  logic signed [SB-1:0]  v,
  input  logic [CW-1:0]         n_before,
  input  logic signed [SB-1:0]  s_prev,
  input  logic signed [SB-1:0]  s_next,
  input  logic                  m_prev,
  input  logic                  g_prev,
  input  logic                  g_next,
  output logic signed [SB-1:0]  s,
  output logic                  m,
  output logic                  g
);
  import swq_pkg::*;

  logic lt;
  logic gt;
  logic signed [SB-1:0] s_next_val;

  // g: slot lies past the insert point, m: slot lies at or past the evicted entry
  assign g = (32'(IDX) >= 32'(n_before)) || (s > x);
  assign m = ctrl.evict && (s >= v);

  assign lt = ctrl.vle ? !g_next : !g;
  assign gt = ctrl.vle ? g : g_prev;

  always_comb begin
    if (lt) begin
      s_next_val = m ? s_next : s;
    end else if (gt) begin
      s_next_val = m_prev ? s : s_prev;
    end else begin
      s_next_val = x;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.upd) begin
      s <= s_next_val;
    end
  end

endmodule

### hdl/sliding_window_quantile_unit.sv
// sliding window quantile unit: top level with control, arrival ring and cell row
//
// input channel: sample with in_valid / in_ready; output channel: quantile_value and
// window_count with out_valid / out_ready. an apb port holds window_length (addr 0)
// and quantile_fraction (addr 4); writing window_length empties the window.
// each accepted sample enters the window (evicting the oldest once full) and one
// result follows: the linearly interpolated q-quantile over the current window.
// a transaction runs through accept (ring read of the oldest slot), cell row
// update, order statistic select and interpolation into the output register; a new
// sample is taken only in idle, once the previous transaction has finished.
// the output register holds a finished result while the receiver stalls; the next
// sample is still accepted, and its last stage waits until the register is free.
// reset is synchronous: registers return to 300 and 0.98, the window is empty and
// the ring and cells need no clearing.
module sliding_window_quantile_unit #(
  parameter int WINDOW_MAX  = swq_pkg::WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = swq_pkg::SAMPLE_BITS_DEF,
  localparam int IDX_W = $clog2(WINDOW_MAX),
  localparam int CNT_W = $clog2(WINDOW_MAX + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [SAMPLE_BITS-1:0] quantile_value,
  output logic [CNT_W-1:0]              window_count
);
  import swq_pkg::*;

  localparam int SB = SAMPLE_BITS;
  localparam int PW = Q_BITS + CNT_W;

  state_t state, state_next;

  logic [LEN_BITS-1:0] window_length;
  logic [Q_BITS-1:0]   quantile_fraction;
  logic [CNT_W-1:0]    fill;
  logic [IDX_W-1:0]    wp;

  logic signed [SB-1:0] arrival_ring [WINDOW_MAX];

  logic signed [SB-1:0] x;
  logic signed [SB-1:0] v;
  logic                 evict;
  logic [CNT_W-1:0]     n_new;
  logic [IDX_W-1:0]     lo;
  logic [IDX_W-1:0]     hi;
  logic [FRAC_BITS-1:0] frac;
  logic signed [SB-1:0] a;
  logic signed [SB-1:0] b;

  logic                 cfg_wr;
  logic                 in_acc;
  logic                 out_load;
  logic [CNT_W-1:0]     len_eff;
  logic [Q_BITS-1:0]    q_eff;
  logic [CNT_W:0]       slot_sum;
  logic [IDX_W-1:0]     old_slot;
  logic [PW-1:0]        pos;
  logic [IDX_W-1:0]     pos_lo;
  logic [IDX_W-1:0]     n_last;
  logic [SB-1:0]        diff;
  logic [SB+FRAC_BITS-1:0] prod;
  cell_ctrl_t           ctrl;

  logic signed [SB-1:0] cs [WINDOW_MAX];
  logic                 cm [WINDOW_MAX];
  logic                 cg [WINDOW_MAX];

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (reg_idx_t'(paddr[2]))
      REG_WINDOW_LENGTH:     prdata = 32'(window_length);
      REG_QUANTILE_FRACTION: prdata = 32'(quantile_fraction);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length     <= LEN_RESET;
      quantile_fraction <= Q_RESET;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[2]))
        REG_WINDOW_LENGTH:     window_length     <= pwdata[LEN_BITS-1:0];
        REG_QUANTILE_FRACTION: quantile_fraction <= pwdata[Q_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign len_eff = (window_length == '0) ? CNT_W'(1) :
                   ((32'(window_length) > 32'(WINDOW_MAX)) ? CNT_W'(WINDOW_MAX) :
                    CNT_W'(window_length));
  assign q_eff   = (quantile_fraction > Q_ONE) ? Q_ONE : quantile_fraction;

  // oldest slot is wp - len modulo the ring size
  assign slot_sum = (CNT_W+1)'(wp) + (CNT_W+1)'(WINDOW_MAX) - (CNT_W+1)'(len_eff);
  assign old_slot = (32'(slot_sum) >= 32'(WINDOW_MAX)) ?
                    IDX_W'(32'(slot_sum) - 32'(WINDOW_MAX)) : IDX_W'(slot_sum);

  // fsm
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: state_next = ST_SELECT;
      ST_SELECT: state_next = ST_INTERP;
      ST_INTERP: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign in_acc = in_valid && in_ready;

  // ring and window bookkeeping
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x     <= sample;
      v     <= arrival_ring[old_slot];
      evict <= (fill == len_eff);
      n_new <= (fill == len_eff) ? fill : fill + CNT_W'(1);
    end
    if (state == ST_UPDATE) begin
      arrival_ring[wp] <= x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      wp   <= '0;
    end else if (cfg_wr && reg_idx_t'(paddr[2]) == REG_WINDOW_LENGTH) begin
      fill <= '0;
      wp   <= '0;
    end else if (state == ST_UPDATE) begin
      fill <= n_new;
      wp   <= (32'(wp) == WINDOW_MAX - 1) ? '0 : wp + IDX_W'(1);
    end
  end

  // position of the quantile among the order statistics
  assign n_last = IDX_W'(n_new - CNT_W'(1));
  assign pos    = PW'(q_eff) * PW'(n_new - CNT_W'(1));
  assign pos_lo = pos[FRAC_BITS +: IDX_W];

  always_ff @(posedge clk) begin
    if (state == ST_UPDATE) begin
      lo   <= pos_lo;
      frac <= pos[FRAC_BITS-1:0];
      hi   <= (pos_lo == n_last) ? pos_lo : pos_lo + IDX_W'(1);
    end
    if (state == ST_SELECT) begin
      a <= cs[lo];
      b <= cs[hi];
    end
  end

  // sorted cell row
  assign ctrl.upd   = (state == ST_UPDATE);
  assign ctrl.evict = evict;
  assign ctrl.vle   = evict && (v <= x);

  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
    swq_cell #(
      .SB  (SB),
      .CW  (CNT_W),
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .x        (x),
      .v        (v),
      .n_before (fill),
      .s_prev   ((i == 0) ? SB'(0) : cs[(i == 0) ? 0 : i-1]),
      .s_next   ((i == WINDOW_MAX-1) ? SB'(0) : cs[(i == WINDOW_MAX-1) ? i : i+1]),
      .m_prev   ((i == 0) ? 1'b0 : cm[(i == 0) ? 0 : i-1]),
      .g_prev   ((i == 0) ? 1'b0 : cg[(i == 0) ? 0 : i-1]),
      .g_next   ((i == WINDOW_MAX-1) ? 1'b1 : cg[(i == WINDOW_MAX-1) ? i : i+1]),
      .s        (cs[i]),
      .m        (cm[i]),
      .g        (cg[i])
    );
  end

  // interpolation between neighboring order statistics
  assign diff = SB'(b - a);
  assign prod = (SB+FRAC_BITS)'(diff) * (SB+FRAC_BITS)'(frac);

  always_ff @(posedge clk) begin
    if (out_load) begin
      quantile_value <= a + $signed(prod[FRAC_BITS +: SB]);
      window_count   <= n_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= len_eff)
    else $error("fill count exceeds window length");

  a_accept_update: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> state == ST_UPDATE)
    else $error("accepted transaction did not reach cell update");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (window_count != '0 && window_count <= CNT_W'(WINDOW_MAX)))
    else $error("window count out of range");

  a_sorted_head: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && fill >= CNT_W'(2)) |-> cs[0] <= cs[1])
    else $error("sorted row out of order");

  a_sel_bounds: assert property (@(posedge clk) disable iff (rst)
    state == ST_SELECT |-> (hi >= lo && 32'(hi) < 32'(n_new)))
    else $error("order statistic index out of window");
`endif

endmodule

### bench/tb_top.sv
// testbench for the sliding window quantile unit
`timescale 1ns / 1ps

module tb_top;
  import swq_pkg::*;

  localparam int WMAX = 512;
  localparam int SW   = 24;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [SW-1:0] sample = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SW-1:0] quantile_value;
  logic [9:0] window_count;

  always #5 clk = ~clk;

  sliding_window_quantile_unit i_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .sample(sample),
    .out_valid(out_valid), .out_ready(out_ready),
    .quantile_value(quantile_value), .window_count(window_count)
  );

  typedef struct packed {
    logic signed [SW-1:0] value;
    logic [9:0]           count;
  } quantile_t;

  // shadow of the window and registers
  logic [9:0]           len_reg;
  logic [16:0]          q_reg;
  logic signed [SW-1:0] ring [WMAX];
  logic signed [SW-1:0] order [WMAX];
  int unsigned          wptr, fill;

  quantile_t expected_q[$];
  int errors = 0;
  int n_results = 0;
  int n_items = 0;
  bit hold_off = 1'b0;

  function automatic void clear_window();
    wptr = 0;
    fill = 0;
  endfunction

  function automatic quantile_t predict_quantile(logic signed [SW-1:0] x);
    int unsigned len, q, n, lo, hi, idx, oldslot;
    longint unsigned pos, frac, diff;
    longint signed a, b;
    logic signed [SW-1:0] gone;
    quantile_t r;
    len = (len_reg == 0) ? 1 : ((len_reg > WMAX) ? WMAX : len_reg);
    q = (q_reg > Q_ONE) ? Q_ONE : q_reg;
    if (fill > len) fill = len;
    if (fill == len) begin
      oldslot = (wptr + WMAX - len) % WMAX;
      gone = ring[oldslot];
      idx = 0;
      while (idx < fill && order[idx] != gone) idx++;
      for (int k = idx; k + 1 < fill; k++) order[k] = order[k+1];
      fill--;
    end
    idx = fill;
    while (idx > 0 && order[idx-1] > x) begin
      order[idx] = order[idx-1];
      idx--;
    end
    order[idx] = x;
    fill++;
    ring[wptr] = x;
    wptr = (wptr + 1) % WMAX;
    n = fill;
    pos = longint'(q) * longint'(n - 1);
    lo = pos >> 16;
    frac = pos & 64'hFFFF;
    if (lo > n - 1) lo = n - 1;
    hi = (lo + 1 > n - 1) ? n - 1 : lo + 1;
    a = order[lo];
    b = order[hi];
    diff = b - a;
    r.value = SW'(a + longint'((diff * frac) >> 16));
    r.count = n[9:0];
    return r;
  endfunction

  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_WINDOW_LENGTH) begin
      len_reg = val[9:0];
      clear_window();
    end else begin
      q_reg = val[16:0];
    end
  endtask

  // drive one sample, wait until it is accepted and queue its predicted result
  task automatic send_sample(logic signed [SW-1:0] x);
    quantile_t r;
    sample <= x;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    r = predict_quantile(x);
    expected_q.push_back(r);
    n_items++;
  endtask

  task automatic idle_sender();
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // receiver side and result check
  always @(posedge clk) begin
    quantile_t e;
    if (!rst && out_valid && out_ready) begin
      n_results++;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %0d/%0d", quantile_value, window_count);
      end else begin
        e = expected_q.pop_front();
        if (e.value !== quantile_value || e.count !== window_count) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected %0d/%0d got %0d/%0d",
                     e.value, e.count, quantile_value, window_count);
        end
      end
    end
  end

  initial begin
    int stall;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_off) out_ready <= 1'b0;
      else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 4) == 0)
          stall = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(1, 3);
      end
    end
  end

  // directed rows; expected value given where obvious, count always checked
  typedef struct {
    logic signed [SW-1:0] x;
    bit                   known;
    logic signed [SW-1:0] value;
  } row_t;

  row_t dir_rows[$];

  initial begin
    quantile_t r;
    logic [31:0] lens [6];
    logic [31:0] qs   [6];
    lens = '{1, 2, 3, 512, 0, 1023};
    qs   = '{0, 65536, 32768, 64225, 131071, 1};
    len_reg = LEN_RESET;
    q_reg = Q_RESET;
    clear_window();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // after reset with default registers: single sample returns itself
    dir_rows.push_back('{-24'sd8388608, 1'b1, -24'sd8388608});
    dir_rows.push_back('{24'sd8388607, 1'b0, 0});
    dir_rows.push_back('{24'sd0, 1'b0, 0});
    dir_rows.push_back('{-24'sd1, 1'b0, 0});
    dir_rows.push_back('{24'sd8388607, 1'b0, 0});
    dir_rows.push_back('{24'sd5, 1'b0, 0});
    foreach (dir_rows[i]) begin
      if (dir_rows[i].known) begin
        r = predict_quantile(dir_rows[i].x);
        if (r.value !== dir_rows[i].value) begin
          errors++;
          $display("directed row %0d: table says %0d", i, dir_rows[i].value);
        end
        expected_q.push_back(r);
        sample <= dir_rows[i].x;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        n_items++;
      end else
        send_sample(dir_rows[i].x);
    end
    drain();

    // quantile change keeps history; extremes of the quantile register
    reg_write(REG_QUANTILE_FRACTION, 0);
    for (int i = 0; i < 4; i++) send_sample(SW'($urandom));
    drain();
    reg_write(REG_QUANTILE_FRACTION, 131071);
    for (int i = 0; i < 4; i++) send_sample(SW'($urandom));
    drain();

    // pressure: receiver held off while the sender keeps going
    hold_off = 1'b1;
    fork
      for (int i = 0; i < 12; i++) send_sample(SW'($urandom));
      repeat (80) @(posedge clk);
    join_any
    hold_off = 1'b0;
    wait fork;
    drain();

    // random phases across register settings
    for (int p = 0; p < 12; p++) begin
      reg_write(REG_WINDOW_LENGTH, (p < 6) ? lens[p] : $urandom_range(1, 40));
      reg_write(REG_QUANTILE_FRACTION, (p < 6) ? qs[p] : $urandom_range(0, 65536));
      for (int i = 0; i < ((p == 3) ? 200 : 60); i++) begin
        case ($urandom_range(0, 3))
          0: send_sample(SW'($urandom));
          1: send_sample(SW'($signed($urandom_range(0, 20)) - 10));
          2: send_sample($urandom_range(0, 1) ? 24'sh7FFFFF : -24'sh800000);
          default: send_sample(SW'($urandom_range(0, 1000)));
        endcase
        idle_sender();
      end
      drain();
    end

    $display("covered %0d samples and %0d results over window lengths 0..1023",
             n_items, n_results);
    $display("and quantile settings from 0 to above 1.0, with stalls on both sides");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d results still expected", errors, expected_q.size());
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("timeout");
    $display("FAIL");
    $finish;
  end

endmodule
